// File: rtl/nearest_point_search_core_defines.svh
// ----------------------------------------------------------------------------
// nearest_point_search_core_defines
// Assertion macros shared by the nearest point search RTL.
// ----------------------------------------------------------------------------
`ifndef NEAREST_POINT_SEARCH_CORE_DEFINES_SVH
`define NEAREST_POINT_SEARCH_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define NPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nps assertion failed");

// next-cycle implication
`define NPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nps assertion failed");

`endif

// File: rtl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Types and constants for the nearest point search core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nps_pkg;

  localparam int POINT_DEPTH_DEF = 1024;
  localparam int COORD_BITS_DEF  = 16;
  localparam int FIELD_W         = 16;
  localparam int INDEX_W         = 10;

  typedef enum logic [1:0] {
    KIND_APPEND   = 2'd0,
    KIND_PREPEND  = 2'd1,
    KIND_QUERY_3D = 2'd2,
    KIND_QUERY_2D = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_DIFF,
    S_MUL,
    S_ACC,
    S_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    kind_e               kind;
    logic signed [FIELD_W-1:0] x_coord;
    logic signed [FIELD_W-1:0] y_coord;
    logic signed [FIELD_W-1:0] z_coord;
  } nps_in_t;

  typedef struct packed {
    status_e             status;
    logic [INDEX_W-1:0]  found_index;
  } nps_out_t;

  typedef struct packed {
    logic clear;
    logic diff_en;
    logic mul_en;
    logic acc_en;
  } dist_ctrl_t;

endpackage

// File: rtl/nps_dist_unit.sv
// ----------------------------------------------------------------------------
// nps_dist_unit
// Shared squared-distance unit: one axis per pass through diff, square and
// accumulate, each step registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nps_dist_unit
  import nps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  dist_ctrl_t                ctrl_i,
  input  logic [COORD_BITS-1:0]     pt_i,
  input  logic [COORD_BITS-1:0]     qry_i,
  output logic [2*COORD_BITS+1:0]   acc_o
);

  localparam int CW = COORD_BITS;
  localparam int AW = 2 * CW + 2;

  logic signed [CW:0]   diff_s;
  logic [CW:0]          diff_abs;
  logic [CW-1:0]        diff_q;
  logic [2*CW-1:0]      prod_q;
  logic [AW-1:0]        acc_q;

  assign diff_s   = $signed({pt_i[CW-1], pt_i}) - $signed({qry_i[CW-1], qry_i});
  assign diff_abs = diff_s[CW] ? $unsigned(-diff_s) : $unsigned(diff_s);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.diff_en) begin
      diff_q <= diff_abs[CW-1:0];
    end
    if (ctrl_i.mul_en) begin
      prod_q <= diff_q * diff_q;
    end
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + AW'(prod_q);
    end
  end

  assign acc_o = acc_q;

endmodule

// File: rtl/nearest_point_search_core.sv
// ----------------------------------------------------------------------------
// nearest_point_search_core
// Ordered point list in a ring with movable base, with append, prepend and
// a linear nearest-point search by squared Euclidean distance.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  in      | input     | in_valid_i / in_stall_o   | nps_in_t
//  out     | output    | out_valid_o / out_stall_i | nps_out_t
//
//  Append/prepend: store write in S_WRITE, result registered in S_DONE.
//  Query: per stored point S_READ, S_DIFF/S_MUL/S_ACC per axis (x, y, z
//  for 3D, x and y for 2D), then S_CMP; an empty store goes to S_DONE. One
//  registered store read per point, then diff/square/add on one shared squarer.
//  Reset clears count and base; the store itself is never cleared.
//  in_stall_o is high while an item is in work; a result waiting under
//  out_stall_i holds the core in its final state until the output frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_point_search_core
  import nps_pkg::*;
#(
  parameter int POINT_DEPTH = POINT_DEPTH_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  nps_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output nps_out_t out_data_o
);

`include "nearest_point_search_core_defines.svh"

  localparam int CW   = COORD_BITS;
  localparam int PW   = 3 * CW;
  localparam int AW   = 2 * CW + 2;
  localparam int IW   = $clog2(POINT_DEPTH);
  localparam int CNTW = $clog2(POINT_DEPTH + 1);

  localparam logic [IW-1:0]   LAST_SLOT = IW'(POINT_DEPTH - 1);
  localparam logic [CNTW-1:0] FULL_CNT  = CNTW'(POINT_DEPTH);
  localparam logic [CNTW:0]   DEPTH_EXT = (CNTW + 1)'(POINT_DEPTH);

  state_e          state_q, state_d;
  kind_e           kind_q;
  logic [PW-1:0]   qpt_q;
  logic [IW-1:0]   base_q;
  logic [CNTW-1:0] cnt_q;
  logic [CNTW-1:0] i_q;
  logic [IW-1:0]   slot_q;
  logic [1:0]      ax_q;
  logic [AW-1:0]   best_q;
  status_e         res_status_q;
  logic [IW-1:0]   res_idx_q;
  nps_out_t        out_q;
  logic            out_valid_q;

  logic [PW-1:0]   mem [POINT_DEPTH];
  logic [PW-1:0]   rd_q;

  logic            in_acc;
  logic            out_free;
  logic            in_is_query;
  logic [31:0]     raw_x, raw_y, raw_z;
  logic [CNTW:0]   app_sum;
  logic [IW-1:0]   app_slot;
  logic [IW-1:0]   pre_slot;
  logic [IW-1:0]   wr_slot;
  logic            mem_we;
  logic            last_ax;
  logic            last_pt;
  logic [CNTW-1:0] i_next;
  logic [IW-1:0]   slot_next;
  logic [CW-1:0]   pt_c, qry_c;
  logic [AW-1:0]   acc;
  dist_ctrl_t      dist_ctrl;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_is_query = (in_data_i.kind == KIND_QUERY_3D) || (in_data_i.kind == KIND_QUERY_2D);

  // coordinates taken as the low COORD_BITS of the zero-extended field
  assign raw_x = 32'($unsigned(in_data_i.x_coord));
  assign raw_y = 32'($unsigned(in_data_i.y_coord));
  assign raw_z = 32'($unsigned(in_data_i.z_coord));

  assign app_sum  = (CNTW + 1)'(base_q) + (CNTW + 1)'(cnt_q);
  assign app_slot = (app_sum >= DEPTH_EXT) ? IW'(app_sum - DEPTH_EXT) : IW'(app_sum);
  assign pre_slot = (base_q == '0) ? LAST_SLOT : IW'(base_q - 1'b1);
  assign wr_slot  = (kind_q == KIND_APPEND) ? app_slot : pre_slot;

  assign last_ax   = (kind_q == KIND_QUERY_2D) ? (ax_q == 2'd1) : (ax_q == 2'd2);
  assign i_next    = CNTW'(i_q + 1'b1);
  assign last_pt   = (i_next == cnt_q);
  assign slot_next = (slot_q == LAST_SLOT) ? '0 : IW'(slot_q + 1'b1);

  always_comb begin
    case (ax_q)
      2'd0:    begin pt_c = rd_q[3*CW-1:2*CW]; qry_c = qpt_q[3*CW-1:2*CW]; end
      2'd1:    begin pt_c = rd_q[2*CW-1:CW];   qry_c = qpt_q[2*CW-1:CW];   end
      default: begin pt_c = rd_q[CW-1:0];      qry_c = qpt_q[CW-1:0];      end
    endcase
  end

  nps_dist_unit #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk_i (clk_i),
    .ctrl_i(dist_ctrl),
    .pt_i  (pt_c),
    .qry_i (qry_c),
    .acc_o (acc)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_is_query) begin
            state_d = S_WRITE;
          end else if (cnt_q == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_WRITE: state_d = S_DONE;
      S_READ:  state_d = S_DIFF;
      S_DIFF:  state_d = S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC:   state_d = last_ax ? S_CMP : S_DIFF;
      S_CMP:   state_d = last_pt ? S_DONE : S_READ;
      S_DONE:  state_d = out_free ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    dist_ctrl  = '0;
    mem_we     = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE:  in_stall_o = 1'b0;
      S_WRITE: mem_we = (cnt_q != FULL_CNT);
      S_READ:  dist_ctrl.clear = 1'b1;
      S_DIFF:  dist_ctrl.diff_en = 1'b1;
      S_MUL:   dist_ctrl.mul_en = 1'b1;
      S_ACC:   dist_ctrl.acc_en = 1'b1;
      S_CMP, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        cnt_q <= CNTW'(cnt_q + 1'b1);
        if (kind_q == KIND_PREPEND) begin
          base_q <= pre_slot;
        end
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q       <= in_data_i.kind;
      qpt_q        <= {raw_x[CW-1:0], raw_y[CW-1:0], raw_z[CW-1:0]};
      i_q          <= '0;
      slot_q       <= base_q;
      res_idx_q    <= '0;
      res_status_q <= (in_is_query && cnt_q == '0) ? STATUS_EMPTY : STATUS_OK;
    end
    if (state_q == S_WRITE) begin
      if (cnt_q == FULL_CNT) begin
        res_status_q <= STATUS_FULL;
      end else if (kind_q == KIND_APPEND) begin
        res_idx_q <= IW'(cnt_q);
      end
    end
    if (state_q == S_READ) begin
      ax_q <= 2'd0;
    end else if (state_q == S_ACC) begin
      ax_q <= 2'(ax_q + 1'b1);
    end
    if (state_q == S_CMP) begin
      if (i_q == '0 || acc < best_q) begin
        best_q    <= acc;
        res_idx_q <= IW'(i_q);
      end
      i_q    <= i_next;
      slot_q <= slot_next;
    end
    if (state_q == S_DONE && out_free) begin
      out_q.status      <= res_status_q;
      out_q.found_index <= INDEX_W'(res_idx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_slot] <= qpt_q;
    end
    rd_q <= mem[slot_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `NPS_ASSERT_NOW(a_count_bounded, 1'b1, cnt_q <= FULL_CNT)
  `NPS_ASSERT_NOW(a_scan_in_range, state_q == S_CMP, i_q < cnt_q)
  `NPS_ASSERT_NEXT(a_store_grows, mem_we, cnt_q == CNTW'($past(cnt_q) + 1'b1))

endmodule

// File: sim/tb_nearest_point_search_core.sv
// ----------------------------------------------------------------------------
// tb_nearest_point_search_core
// Self-checking bench for the nearest point search core. A tracker class
// mirrors the point ring (append, prepend, wrap) and predicts the nearest
// index of every query. Directed words hit the empty store, extreme
// coordinates and ties. Random words keep the list short, and a final phase
// runs queries on stored points across the list.
// Both sides idle and stall at random, with one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nearest_point_search_core;
  import nps_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 9;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_WORDS   = 550;
  localparam int SETTLE_CYCLES  = 30;

  class point_list_tracker;
    logic signed [FIELD_W-1:0] px [POINT_DEPTH_DEF];
    logic signed [FIELD_W-1:0] py [POINT_DEPTH_DEF];
    logic signed [FIELD_W-1:0] pz [POINT_DEPTH_DEF];
    logic [INDEX_W-1:0] base = '0;
    int count = 0;
    int mismatch_count = 0;
    nps_out_t expected_results[$];

    task report_mismatch(string msg);
      mismatch_count++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    function nps_in_t stored_point_word(int idx);
      nps_in_t p;
      logic [INDEX_W-1:0] slot;
      slot = base + INDEX_W'(idx);
      p.kind    = KIND_QUERY_3D;
      p.x_coord = px[slot];
      p.y_coord = py[slot];
      p.z_coord = pz[slot];
      return p;
    endfunction

    // updates the ring and returns the result the core must give
    function nps_out_t apply_word(nps_in_t w);
      nps_out_t r;
      logic [INDEX_W-1:0] slot;
      longint dx, dy, dz, sq_sum, best;
      r.status = STATUS_OK;
      r.found_index = '0;
      best = 0;
      if (w.kind == KIND_APPEND || w.kind == KIND_PREPEND) begin
        if (count >= POINT_DEPTH_DEF) begin
          r.status = STATUS_FULL;
        end else begin
          if (w.kind == KIND_APPEND) begin
            slot = base + INDEX_W'(count);
            r.found_index = INDEX_W'(count);
          end else begin
            base = base - 1'b1;
            slot = base;
          end
          px[slot] = w.x_coord;
          py[slot] = w.y_coord;
          pz[slot] = w.z_coord;
          count++;
        end
      end else if (count == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        for (int i = 0; i < count; i++) begin
          slot = base + INDEX_W'(i);
          dx = longint'(px[slot]) - longint'($signed(w.x_coord));
          dy = longint'(py[slot]) - longint'($signed(w.y_coord));
          dz = longint'(pz[slot]) - longint'($signed(w.z_coord));
          sq_sum = dx * dx + dy * dy;
          if (w.kind == KIND_QUERY_3D) sq_sum += dz * dz;
          if (i == 0 || sq_sum < best) begin
            best = sq_sum;
            r.found_index = INDEX_W'(i);
          end
        end
      end
      return r;
    endfunction

    function void note_word(nps_in_t w);
      expected_results.insert(expected_results.size(), apply_word(w));
    endfunction

    task check_word(nps_out_t got);
      nps_out_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: status %0d index %0d",
                                  got.status, got.found_index));
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d expected %0d", got.status, want.status));
      if (got.found_index !== want.found_index)
        report_mismatch($sformatf("found_index got %0d expected %0d",
                                  got.found_index, want.found_index));
    endtask

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  nps_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  nps_out_t out_data;

  point_list_tracker tracker = new;

  int burst_left  = 0;
  int idle_cycles = 0;
  int rx_cycle    = 0;
  int hold_left   = 0;
  bit hold_req    = 1'b0;

  nearest_point_search_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) tracker.note_word(in_data);
      if (out_valid && !out_stall) tracker.check_word(out_data);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: long hold-off on request, otherwise a rotating stall pattern
  always @(negedge clk_i) begin
    rx_cycle++;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case ((rx_cycle / 200) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ((rx_cycle % 7) < 3);
        default: out_stall <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  task automatic send_word(nps_in_t w);
    int gap;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid <= 1'b0;
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic nps_in_t make_word(kind_e k, int x, int y, int z);
    nps_in_t w;
    w.kind    = k;
    w.x_coord = FIELD_W'(x);
    w.y_coord = FIELD_W'(y);
    w.z_coord = FIELD_W'(z);
    return w;
  endfunction

  function automatic logic signed [FIELD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2, 3: return FIELD_W'($urandom_range(0, 16) - 8);
      default: return FIELD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic nps_in_t random_word();
    nps_in_t w;
    nps_in_t p;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) w.kind = KIND_APPEND;
    else if (pick < 25) w.kind = KIND_PREPEND;
    else if (pick < 65) w.kind = KIND_QUERY_3D;
    else w.kind = KIND_QUERY_2D;
    w.x_coord = rand_coord();
    w.y_coord = rand_coord();
    w.z_coord = rand_coord();
    // queries close to a stored point make the scan order matter
    if (pick >= 25 && tracker.count > 0 && $urandom_range(0, 2) == 0) begin
      p = tracker.stored_point_word($urandom_range(0, tracker.count - 1));
      w.x_coord = p.x_coord + FIELD_W'($urandom_range(0, 6) - 3);
      w.y_coord = p.y_coord + FIELD_W'($urandom_range(0, 6) - 3);
      w.z_coord = p.z_coord + FIELD_W'($urandom_range(0, 6) - 3);
    end
    return w;
  endfunction

  initial begin
    nps_in_t p;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_word(make_word(KIND_QUERY_3D, 0, 0, 0));
    send_word(make_word(KIND_QUERY_2D, 32767, 32767, 32767));
    send_word(make_word(KIND_APPEND, 32767, 32767, 32767));
    send_word(make_word(KIND_APPEND, -32768, -32768, -32768));
    send_word(make_word(KIND_PREPEND, 0, 0, 0));
    send_word(make_word(KIND_QUERY_3D, 32767, 32767, 32767));
    send_word(make_word(KIND_QUERY_3D, -32768, -32768, -32768));
    send_word(make_word(KIND_QUERY_2D, -32768, -32768, 32767));
    send_word(make_word(KIND_QUERY_3D, 32767, -32768, 0));
    send_word(make_word(KIND_APPEND, 0, 0, 0));
    send_word(make_word(KIND_QUERY_3D, 0, 0, 0));
    send_word(make_word(KIND_PREPEND, 100, -100, 5));
    send_word(make_word(KIND_QUERY_2D, 100, -100, -32768));
    send_word(make_word(KIND_APPEND, 2, 0, 0));
    send_word(make_word(KIND_QUERY_3D, 1, 0, 0));
    send_word(make_word(KIND_QUERY_2D, 1, 0, 12345));
    send_word(make_word(KIND_PREPEND, -1, -1, -1));
    send_word(make_word(KIND_QUERY_3D, -32768, 32767, -32768));
    drain_results();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 200) hold_req = 1'b1;
      if (i == 360) drain_results();
      send_word(random_word());
    end
    drain_results();

    // queries landing on stored points at both ends and inside the list
    send_word(tracker.stored_point_word(tracker.count - 1));
    send_word(tracker.stored_point_word(tracker.count / 2));
    send_word(tracker.stored_point_word(0));
    send_word(tracker.stored_point_word($urandom_range(0, tracker.count - 1)));
    p = tracker.stored_point_word($urandom_range(0, tracker.count - 1));
    p.kind = KIND_QUERY_2D;
    p.z_coord = FIELD_W'($urandom_range(0, 65535));
    send_word(p);
    drain_results();

    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/nps_pkg.sv
rtl/nps_dist_unit.sv
rtl/nearest_point_search_core.sv
sim/tb_nearest_point_search_core.sv
